FILE: rtl/lrc_timestamp_tag_parser_assert.svh
// ----------------------------------------------------------------------------
// lrc_timestamp_tag_parser_assert.svh
// Assertion macros shared by the timestamp tag parser modules. Each macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRC_TIMESTAMP_TAG_PARSER_ASSERT_SVH
`define LRC_TIMESTAMP_TAG_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrc timestamp tag parser: assertion failed");
`define LRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrc timestamp tag parser: assertion failed");
`else
`define LRC_ASSERT_IMP(label, ante, cons)
`define LRC_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Widths, character codes, limits and the finish beat type of the lyric
// timestamp tag parser.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int CH_W     = 8;
  localparam int MIN_W    = 10;
  localparam int SEC_W    = 6;
  localparam int FRAC_W   = 10;
  localparam int FCNT_W   = 2;
  localparam int SECS_W   = 16;
  localparam int MS_W     = 10;
  localparam int T_W      = 26;
  localparam int MICROS_W = 36;

  localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;

  localparam logic [MIN_W-1:0]  MAX_MINUTES     = 10'd999;
  localparam logic [MIN_W-1:0]  MIN_SAT         = 10'd1000;
  localparam logic [SEC_W-1:0]  SECONDS_LIMIT   = 6'd60;
  localparam logic [FCNT_W-1:0] MAX_FRAC_DIGITS = 2'd3;

  localparam logic [SECS_W-1:0]   SEC_PER_MIN = 16'd60;
  localparam logic [T_W-1:0]      MS_PER_S    = 26'd1000;
  localparam logic [MICROS_W-1:0] US_PER_MS   = 36'd1000;
  localparam logic [MICROS_W-1:0] MAX_MICROS  = 36'd59999999000;

  typedef struct packed {
    logic              ok;
    logic [SECS_W-1:0] secs;
    logic [MS_W-1:0]   ms;
  } lrc_fin_t;

endpackage

FILE: rtl/lrc_tag_parse.sv
// ----------------------------------------------------------------------------
// lrc_tag_parse
// Per-byte tag scanner: phase, field accumulators and reject flag. On a
// closing bracket or a last byte it forms the finish beat (seconds total and
// milliseconds) and returns to its reset state.
// ----------------------------------------------------------------------------
`include "lrc_timestamp_tag_parser_assert.svh"

module lrc_tag_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [lrc_pkg::CH_W-1:0]  ch,
  input  logic                      last,
  output logic                      fin_valid,
  output lrc_pkg::lrc_fin_t         fin
);
  import lrc_pkg::*;

  localparam logic [1:0] PH_OPEN = 2'd0;
  localparam logic [1:0] PH_MIN  = 2'd1;
  localparam logic [1:0] PH_SEC  = 2'd2;
  localparam logic [1:0] PH_FRAC = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [MIN_W-1:0]  minute_r, minute_nxt;
  logic [SEC_W-1:0]  second_r, second_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [FCNT_W-1:0] fcount_r, fcount_nxt;
  logic              has_digit_r, has_digit_nxt;
  logic              rejected_r, rejected_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [13:0]       min_prod;
  logic [9:0]        sec_prod;
  logic [FRAC_W-1:0] frac_prod;
  logic              closing;
  logic              emit;
  logic              ok;
  logic [MS_W-1:0]   ms_raw;
  logic [SECS_W-1:0] secs_raw;

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit     = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
  assign min_prod  = 14'(minute_r) * 14'd10 + 14'(digit);
  assign sec_prod  = 10'(second_r) * 10'd10 + 10'(digit);
  assign frac_prod = frac_r * 10'd10 + 10'(digit);
  assign closing   = (ch == CH_RBRACK) && (phase_r != PH_OPEN);
  assign emit      = (ch == CH_RBRACK) || last;

  always_comb begin
    phase_nxt     = phase_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    frac_nxt      = frac_r;
    fcount_nxt    = fcount_r;
    has_digit_nxt = has_digit_r;
    rejected_nxt  = rejected_r;
    if (take) begin
      if (emit) begin
        phase_nxt     = PH_OPEN;
        minute_nxt    = '0;
        second_nxt    = '0;
        frac_nxt      = '0;
        fcount_nxt    = '0;
        has_digit_nxt = 1'b0;
        rejected_nxt  = 1'b0;
      end else if (!rejected_r) begin
        unique case (phase_r)
          PH_OPEN: begin
            if (ch == CH_LBRACK) phase_nxt = PH_MIN;
            else rejected_nxt = 1'b1;
          end
          PH_MIN: begin
            if (is_digit) begin
              minute_nxt    = (min_prod > 14'(MIN_SAT)) ? MIN_SAT : MIN_W'(min_prod);
              has_digit_nxt = 1'b1;
            end else if (ch == CH_COLON && has_digit_r) begin
              phase_nxt     = PH_SEC;
              has_digit_nxt = 1'b0;
            end else begin
              rejected_nxt = 1'b1;
            end
          end
          PH_SEC: begin
            if (is_digit) begin
              second_nxt    = (sec_prod > 10'(SECONDS_LIMIT)) ? SECONDS_LIMIT
                                                               : SEC_W'(sec_prod);
              has_digit_nxt = 1'b1;
            end else if (ch == CH_DOT && has_digit_r) begin
              phase_nxt = PH_FRAC;
            end else begin
              rejected_nxt = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit && fcount_r < MAX_FRAC_DIGITS) begin
              frac_nxt   = frac_prod;
              fcount_nxt = fcount_r + 2'd1;
            end else begin
              rejected_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    case (fcount_r)
      2'd1:    ms_raw = frac_r * 10'd100;
      2'd2:    ms_raw = frac_r * 10'd10;
      2'd3:    ms_raw = frac_r;
      default: ms_raw = '0;
    endcase
  end

  assign secs_raw = SECS_W'(minute_r) * SEC_PER_MIN + SECS_W'(second_r);

  assign ok = closing && !rejected_r && (phase_r == PH_SEC || phase_r == PH_FRAC)
              && has_digit_r && (minute_r <= MAX_MINUTES) && (second_r < SECONDS_LIMIT)
              && !(phase_r == PH_FRAC && fcount_r == '0);

  assign fin_valid = take && emit;
  assign fin.ok    = ok;
  assign fin.secs  = ok ? secs_raw : '0;
  assign fin.ms    = ok ? ms_raw : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      minute_r    <= '0;
      second_r    <= '0;
      frac_r      <= '0;
      fcount_r    <= '0;
      has_digit_r <= 1'b0;
      rejected_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      frac_r      <= frac_nxt;
      fcount_r    <= fcount_nxt;
      has_digit_r <= has_digit_nxt;
      rejected_r  <= rejected_nxt;
    end
  end

  `LRC_ASSERT_IMP(a_open_clean, phase_r == PH_OPEN, minute_r == '0 && has_digit_r == 1'b0 && fcount_r == '0)
  `LRC_ASSERT_IMP(a_frac_phase, fcount_r != '0, phase_r == PH_FRAC)
  `LRC_ASSERT_IMP(a_acc_sat, 1'b1, minute_r <= MIN_SAT && second_r <= SECONDS_LIMIT)

endmodule

FILE: rtl/lrc_time_scale.sv
// ----------------------------------------------------------------------------
// lrc_time_scale
// Three-register result pipeline: holds the finish beat, scales seconds to
// milliseconds, then milliseconds to microseconds into the output register.
// ----------------------------------------------------------------------------
`include "lrc_timestamp_tag_parser_assert.svh"

module lrc_time_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fin_valid,
  input  lrc_pkg::lrc_fin_t             fin,
  output logic                          fin_ready,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_valid_res,
  output logic [lrc_pkg::MICROS_W-1:0]  out_micros
);
  import lrc_pkg::*;

  logic                v1_r, v1_nxt;
  lrc_fin_t            s1_r;
  logic                v2_r, v2_nxt;
  logic                ok2_r;
  logic [T_W-1:0]      t2_r;
  logic [T_W-1:0]      t2_nxt;
  logic                vo_r, vo_nxt;
  logic                res_r;
  logic [MICROS_W-1:0] micros_r;
  logic [MICROS_W-1:0] micros_nxt;
  logic                rdy2, rdy3;

  assign rdy3      = !vo_r || !out_stall;
  assign rdy2      = !v2_r || rdy3;
  assign fin_ready = !v1_r || rdy2;

  assign v1_nxt = fin_ready ? fin_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign vo_nxt = rdy3 ? v2_r : vo_r;

  assign t2_nxt     = T_W'(s1_r.secs) * MS_PER_S + T_W'(s1_r.ms);
  assign micros_nxt = MICROS_W'(t2_r) * US_PER_MS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) s1_r <= fin;
    if (v1_r && rdy2) begin
      ok2_r <= s1_r.ok;
      t2_r  <= t2_nxt;
    end
    if (v2_r && rdy3) begin
      res_r    <= ok2_r;
      micros_r <= micros_nxt;
    end
  end

  assign out_valid     = vo_r;
  assign out_valid_res = res_r;
  assign out_micros    = micros_r;

  `LRC_ASSERT_NXT(a_s1_hold, v1_r && !rdy2, v1_r && $stable(s1_r))
  `LRC_ASSERT_IMP(a_s2_zero, v2_r && !ok2_r, t2_r == '0)
  `LRC_ASSERT_IMP(a_out_zero, vo_r && !res_r, micros_r == '0)
  `LRC_ASSERT_IMP(a_out_range, vo_r, micros_r <= MAX_MICROS)

endmodule

FILE: rtl/lrc_timestamp_tag_parser.sv
// ----------------------------------------------------------------------------
// lrc_timestamp_tag_parser
// Lyric timestamp tag parser: checks "[mm:ss]" or "[mm:ss.f]" one byte per
// beat and returns a valid flag and the time in microseconds per tag.
//
//   channel   direction  handshake          payload
//   in_       sink       in_valid/in_stall   in_ch[7:0], in_last
//   out_      source     out_valid/out_stall out_valid_res, out_micros[35:0]
//
// One byte per cycle while in_stall is low; the scanner updates its state on
// the accepted beat. A result passes through the finish register, the
// milliseconds multiply and the microseconds multiply to the output register.
// Reset clears the scanner state and all pipeline valid flags.
// in_stall rises only when all three result registers are full and out_stall
// holds the output.
// ----------------------------------------------------------------------------
module lrc_timestamp_tag_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrc_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_valid_res,
  output logic [lrc_pkg::MICROS_W-1:0]  out_micros
);
  import lrc_pkg::*;

  logic     take;
  logic     fin_valid;
  logic     fin_ready;
  lrc_fin_t fin;

  assign in_stall = !fin_ready;
  assign take     = in_valid && fin_ready;

  lrc_tag_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .ch        (in_ch),
    .last      (in_last),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  lrc_time_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .fin_valid     (fin_valid),
    .fin           (fin),
    .fin_ready     (fin_ready),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_valid_res (out_valid_res),
    .out_micros    (out_micros)
  );

endmodule

FILE: verif/lrc_tag_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrc_tag_check_pkg
// Timestamp tag checker: keeps its own copy of the scanner state, turns each
// closing or last accepted input beat into the tag result it must cause, and
// compares each result beat field by field against the oldest pending tag.
// ----------------------------------------------------------------------------
package lrc_tag_check_pkg;

  import lrc_pkg::*;

  typedef enum logic [1:0] {
    SCAN_OPEN,
    SCAN_MINUTES,
    SCAN_SECONDS,
    SCAN_FRACTION
  } scan_phase_e;

  typedef struct packed {
    logic                ok;
    logic [MICROS_W-1:0] micros;
  } tag_time_t;

  class tag_timestamp_checker;

    scan_phase_e       phase;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [FRAC_W-1:0] fraction;
    logic [2:0]        frac_digits;
    logic              seen_digit;
    logic              bad;

    tag_time_t pending_tags[$];
    int        mismatches;
    int        tags_checked;
    int        tags_ok;

    function new();
      clear_scan();
      mismatches   = 0;
      tags_checked = 0;
      tags_ok      = 0;
    endfunction

    function void clear_scan();
      phase       = SCAN_OPEN;
      minutes     = '0;
      seconds     = '0;
      fraction    = '0;
      frac_digits = '0;
      seen_digit  = 1'b0;
      bad         = 1'b0;
    endfunction

    function int outstanding();
      return pending_tags.size();
    endfunction

    function void queue_tag(tag_time_t t);
      pending_tags.insert(pending_tags.size(), t);
    endfunction

    function void scan_char(logic [CH_W-1:0] ch);
      logic is_digit;
      int   d;
      int   v;
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      d = is_digit ? int'(ch) - int'(CH_ZERO) : 0;
      if (bad) return;
      case (phase)
        SCAN_OPEN: begin
          if (ch == CH_LBRACK) phase = SCAN_MINUTES;
          else bad = 1'b1;
        end
        SCAN_MINUTES: begin
          if (is_digit) begin
            v = int'(minutes) * 10 + d;
            minutes = (v > int'(MIN_SAT)) ? MIN_SAT : MIN_W'(v);
            seen_digit = 1'b1;
          end else if (ch == CH_COLON && seen_digit) begin
            phase = SCAN_SECONDS;
            seen_digit = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end
        SCAN_SECONDS: begin
          if (is_digit) begin
            v = int'(seconds) * 10 + d;
            seconds = (v > int'(SECONDS_LIMIT)) ? SECONDS_LIMIT : SEC_W'(v);
            seen_digit = 1'b1;
          end else if (ch == CH_DOT && seen_digit) begin
            phase = SCAN_FRACTION;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          if (is_digit && frac_digits < MAX_FRAC_DIGITS) begin
            fraction = FRAC_W'(int'(fraction) * 10 + d);
            frac_digits++;
          end else begin
            bad = 1'b1;
          end
        end
      endcase
    endfunction

    function tag_time_t tag_time(logic closed);
      tag_time_t r;
      longint    ms;
      r = '0;
      if (!closed || bad || phase == SCAN_OPEN || phase == SCAN_MINUTES) return r;
      if (!seen_digit || minutes > MAX_MINUTES || seconds >= SECONDS_LIMIT) return r;
      ms = 0;
      if (phase == SCAN_FRACTION) begin
        if (frac_digits == 0) return r;
        case (frac_digits)
          3'd1:    ms = longint'(fraction) * 100;
          3'd2:    ms = longint'(fraction) * 10;
          default: ms = longint'(fraction);
        endcase
      end
      r.ok     = 1'b1;
      r.micros = MICROS_W'(longint'(minutes) * 60000000 + longint'(seconds) * 1000000
                           + ms * longint'(US_PER_MS));
      return r;
    endfunction

    function void note_beat(logic [CH_W-1:0] ch, logic last);
      logic closing;
      if (ch == CH_RBRACK && phase == SCAN_OPEN) begin
        queue_tag('0);
        clear_scan();
        return;
      end
      closing = (ch == CH_RBRACK);
      if (!closing) scan_char(ch);
      if (!closing && !last) return;
      queue_tag(tag_time(closing));
      clear_scan();
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(logic ok, logic [MICROS_W-1:0] micros);
      tag_time_t want;
      if (pending_tags.size() == 0) begin
        report("unexpected result beat (valid_res)", 0, ok);
        return;
      end
      want = pending_tags.pop_front();
      tags_checked++;
      if (want.ok) tags_ok++;
      if (ok !== want.ok) report("valid_res", want.ok, ok);
      if (micros !== want.micros) report("micros", want.micros, micros);
    endfunction

  endclass

endpackage

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Timestamp tag parser check: streams directed tags, then random tags that
// are mostly well-formed, mangled tags and byte noise through the block under
// several idle and stall mixes, including a long output hold-off, and checks
// every result beat against the tag checker.
// ----------------------------------------------------------------------------
module testbench;

  import lrc_pkg::*;
  import lrc_tag_check_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int BYTES_PER_PHASE = 120;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [CH_W-1:0]     in_ch     = '0;
  logic                in_last   = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_valid_res;
  logic [MICROS_W-1:0] out_micros;

  tag_timestamp_checker chk;
  logic [CH_W-1:0]      tag_bytes[$];
  int                   send_idle_pct = 0;
  int                   stall_pct     = 0;
  bit                   hold_req      = 1'b0;
  int                   bytes_sent    = 0;

  lrc_timestamp_tag_parser i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch         (in_ch),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_micros    (out_micros)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [CH_W-1:0] ch, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= ch;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic last_on_final);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_on_final && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.outstanding() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(logic [CH_W-1:0] b);
    tag_bytes.insert(tag_bytes.size(), b);
  endfunction

  function automatic void push_digits(int value, int count);
    for (int i = count - 1; i >= 0; i--)
      add_byte(CH_ZERO + CH_W'((value / (10 ** i)) % 10));
  endfunction

  function automatic void build_tag();
    int min_digits;
    int sec_digits;
    int sec_max;
    int frac_pick;
    int frac_count;
    tag_bytes.delete();
    add_byte(CH_LBRACK);
    min_digits = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
    push_digits($urandom_range(0, 10 ** min_digits - 1), min_digits);
    add_byte(CH_COLON);
    sec_digits = ($urandom_range(9) == 0) ? 3 : $urandom_range(1, 2);
    sec_max = (sec_digits == 2 && $urandom_range(9) != 0) ? 59 : 10 ** sec_digits - 1;
    push_digits($urandom_range(0, sec_max), sec_digits);
    frac_pick = $urandom_range(19);
    if (frac_pick >= 8) begin
      add_byte(CH_DOT);
      frac_count = (frac_pick == 8) ? 0 : (frac_pick == 9) ? 4 : $urandom_range(1, 3);
      push_digits($urandom_range(0, 10 ** frac_count - 1), frac_count);
    end
  endfunction

  function automatic void mangle_tag();
    int pos;
    pos = $urandom_range(0, tag_bytes.size() - 1);
    case ($urandom_range(2))
      0: tag_bytes[pos] = CH_W'($urandom_range(0, 255));
      1: tag_bytes.delete(pos);
      default: begin
        case ($urandom_range(3))
          0:       tag_bytes.insert(pos, CH_COLON);
          1:       tag_bytes.insert(pos, CH_DOT);
          2:       tag_bytes.insert(pos, CH_LBRACK);
          default: tag_bytes.insert(pos, CH_RBRACK);
        endcase
      end
    endcase
  endfunction

  task automatic send_random_tag();
    int   kind;
    int   n;
    logic end_last;
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(CH_W'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(19) == 0));
    end else begin
      build_tag();
      if (kind < 30) mangle_tag();
      if ($urandom_range(99) < 85) begin
        add_byte(CH_RBRACK);
        end_last = ($urandom_range(9) == 0);
      end else begin
        end_last = 1'b1;
      end
      for (int i = 0; i < tag_bytes.size(); i++)
        send_byte(tag_bytes[i], (i == tag_bytes.size() - 1) ? end_last : 1'b0);
    end
  endtask

  // hold for a long stretch on request, else stall at the current rate
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : beat_monitor
    int quiet;
    bit moved;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      moved = 1'b0;
      if (rst_n) begin
        if (in_valid && !in_stall) begin
          chk.note_beat(in_ch, in_last);
          moved = 1'b1;
        end
        if (out_valid && !out_stall) begin
          chk.check_result(out_valid_res, out_micros);
          moved = 1'b1;
        end
      end
      quiet = moved ? 0 : quiet + 1;
    end
    $display("[%0t] no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("** lrc_timestamp_tag_parser: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int phase_end;
    chk = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_text("]", 1'b0);
    send_text("q", 1'b1);
    send_text("[999:59.999]", 1'b0);
    send_text("[0:0.0000]", 1'b0);
    send_text("[5]", 1'b0);
    send_text("[1:2:", 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      if (p == 0) hold_req = 1'b1;
      phase_end = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < phase_end) send_random_tag();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes; checked %0d tag results, %0d of them well-formed; %0d mismatches.",
             bytes_sent, chk.tags_checked, chk.tags_ok, chk.mismatches);
    $display("Mixes: free flow with a %0d-cycle output hold-off, sender idle, receiver stall, both.",
             HOLD_CYCLES);
    if (chk.mismatches == 0 && chk.outstanding() == 0) begin
      $display("** lrc_timestamp_tag_parser: PASSED **");
    end else begin
      $display("** lrc_timestamp_tag_parser: FAILED **");
    end
    $finish;
  end

endmodule
